// ----- rtl/core/lcdnw_pkg.sv -----
// Package for the character LCD nibble writer.
// Holds command and config codes, timing constants, init tables, strobe struct.
// No dependencies.
package lcdnw_pkg;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_DATA  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_ENABLE_WIDTH    = 2'd0,
        CFG_LINE_LENGTH     = 2'd1,
        CFG_SECOND_LINE_CMD = 2'd2
    } t_cfg_idx;

    localparam logic [15:0] INIT_NIBBLE_SETTLE = 16'd30000;
    localparam logic [15:0] BYTE_SETTLE        = 16'd1000;
    localparam logic [15:0] INIT_CMD_SETTLE    = 16'd1800;
    localparam logic [15:0] CLEAR_SETTLE       = 16'd11000;
    localparam logic [6:0]  COUNT_MAX          = 7'd127;
    localparam logic [7:0]  CLEAR_BYTE         = 8'h01;

    localparam logic [7:0] ENABLE_WIDTH_RST    = 8'd25;
    localparam logic [6:0] LINE_LENGTH_RST     = 7'd16;
    localparam logic [7:0] SECOND_LINE_CMD_RST = 8'hC1;

    // Strobe counts less one for each kind of burst
    localparam logic [3:0] LAST_IDX_INIT = 4'd11;
    localparam logic [3:0] LAST_IDX_BYTE = 4'd1;
    localparam logic [3:0] LAST_IDX_WRAP = 4'd3;

    typedef logic [0:3][7:0] t_byte_tab;
    localparam t_byte_tab INIT_NIBBLES = '{8'h30, 8'h30, 8'h30, 8'h20};
    localparam t_byte_tab INIT_CMDS    = '{8'h28, 8'h0C, 8'h06, 8'h80};

    // One strobe as it leaves the generator
    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] settle_count;
        logic        last;
    } t_strobe;

endpackage

// ----- rtl/core/lcdnw_strobe_gen.sv -----
// Strobe generator: maps a burst descriptor and strobe index to one strobe.
// Depends on lcdnw_pkg.
module lcdnw_strobe_gen (
    input  lcdnw_pkg::t_cmd    i_kind,
    input  logic [7:0]         i_byte,
    input  logic               i_wrap,
    input  logic [7:0]         i_wrap_cmd,
    input  logic [3:0]         i_idx,
    output lcdnw_pkg::t_strobe o_strobe
);

    logic [7:0] sel_byte;
    logic [1:0] init_k;
    logic [3:0] last_idx;

    // Init command bytes start at index 4; two strobes per byte
    assign init_k = 2'(i_idx[2:1] - 2'd2);

    always_comb begin
        o_strobe = '0;
        sel_byte = 8'h00;
        last_idx = lcdnw_pkg::LAST_IDX_BYTE;
        unique case (i_kind)
            lcdnw_pkg::CMD_INIT: begin
                last_idx = lcdnw_pkg::LAST_IDX_INIT;
                if (i_idx < 4'd4) begin
                    o_strobe.nibble       = lcdnw_pkg::INIT_NIBBLES[i_idx[1:0]][7:4];
                    o_strobe.settle_count = lcdnw_pkg::INIT_NIBBLE_SETTLE;
                end else begin
                    sel_byte = lcdnw_pkg::INIT_CMDS[init_k];
                    o_strobe.nibble = i_idx[0] ? sel_byte[3:0] : sel_byte[7:4];
                    o_strobe.settle_count = i_idx[0] ? lcdnw_pkg::INIT_CMD_SETTLE : 16'd0;
                end
            end
            lcdnw_pkg::CMD_BYTE: begin
                o_strobe.nibble = i_idx[0] ? i_byte[3:0] : i_byte[7:4];
                o_strobe.settle_count = i_idx[0] ? lcdnw_pkg::BYTE_SETTLE : 16'd0;
            end
            lcdnw_pkg::CMD_DATA: begin
                last_idx = i_wrap ? lcdnw_pkg::LAST_IDX_WRAP : lcdnw_pkg::LAST_IDX_BYTE;
                // The character itself, then the line wrap command if any
                sel_byte = i_idx[1] ? i_wrap_cmd : i_byte;
                o_strobe.reg_select = ~i_idx[1];
                o_strobe.nibble = i_idx[0] ? sel_byte[3:0] : sel_byte[7:4];
                o_strobe.settle_count = i_idx[0] ? lcdnw_pkg::BYTE_SETTLE : 16'd0;
            end
            lcdnw_pkg::CMD_CLEAR: begin
                sel_byte = lcdnw_pkg::CLEAR_BYTE;
                o_strobe.nibble = i_idx[0] ? sel_byte[3:0] : sel_byte[7:4];
                o_strobe.settle_count = i_idx[0] ? lcdnw_pkg::CLEAR_SETTLE : 16'd0;
            end
            default: ;
        endcase
        o_strobe.last = (i_idx == last_idx);
    end

endmodule

// ----- rtl/core/char_lcd_nibble_writer.sv -----
// Top level of the character LCD nibble writer.
// Depends on lcdnw_pkg and lcdnw_strobe_gen.
//
// Usage:
//   The slave stream takes one request per transaction: tuser carries the
//   request code (initialise, command byte, data character, clear display),
//   tdata the byte and the first-of-string flag. The master stream gives one
//   transaction per enable strobe of a 4-bit HD44780-style interface: tuser
//   is the register-select level, tdata the nibble and the settle count in
//   delay loop units, and tlast marks the final strobe of a request.
//   A request produces twelve strobes for initialise, four for a data
//   character that wraps to the second line and two otherwise. The first
//   strobe passes through the burst register and then the output register.
//   The next request is accepted in the cycle that the last strobe of the
//   current one moves into the output register, so bursts follow each other
//   with no gap while the master side is ready.
//   A stalled master side holds the output register, the burst freezes and
//   the slave side stops taking requests once the burst register is full.
//   Reset empties both registers, clears the character counter and loads the
//   configuration registers with their defaults. The configuration channel
//   is always ready and is meant to be written only while the block is idle.
module char_lcd_nibble_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] byte_value, [8] first_of_string, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Strobes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] nibble, [19:4] settle_count, rest zero
    output logic        m_tuser,   // [0] reg_select
    output logic        m_tlast,   // last
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Enable pulse high time for the strobe timing logic outside
    output logic [7:0]  o_enable_width
);

    // Configuration registers. The enable width is kept for the strobe
    // timing logic outside; it does not alter any strobe field.
    logic [7:0] r_enable_width;
    logic [6:0] r_line_length;
    logic [7:0] r_second_line_cmd;

    // Burst register: the request currently being turned into strobes
    logic               r_b_valid;
    lcdnw_pkg::t_cmd    r_b_kind;
    logic [7:0]         r_b_byte;
    logic               r_b_wrap;
    logic [3:0]         r_b_idx;

    // Character counter of the current string
    logic [6:0]         r_char_count;
    logic [6:0]         n_char_count;
    logic               n_wrap;
    logic [6:0]         count_base;

    // Output register
    logic               r_out_valid;
    lcdnw_pkg::t_strobe r_out;
    lcdnw_pkg::t_strobe strobe;

    logic               in_fire;
    logic               out_free;
    lcdnw_pkg::t_cmd    in_cmd;

    assign in_cmd   = lcdnw_pkg::t_cmd'(s_tuser);
    assign out_free = ~r_out_valid | m_tready;
    assign s_tready = ~r_b_valid | (out_free & strobe.last);
    assign in_fire  = s_tvalid & s_tready;

    assign o_cfg_ready    = 1'b1;
    assign o_enable_width = r_enable_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_width    <= lcdnw_pkg::ENABLE_WIDTH_RST;
            r_line_length     <= lcdnw_pkg::LINE_LENGTH_RST;
            r_second_line_cmd <= lcdnw_pkg::SECOND_LINE_CMD_RST;
        end else if (i_cfg_valid) begin
            unique case (lcdnw_pkg::t_cfg_idx'(i_cfg_index))
                lcdnw_pkg::CFG_ENABLE_WIDTH:    r_enable_width    <= i_cfg_data;
                lcdnw_pkg::CFG_LINE_LENGTH:     r_line_length     <= i_cfg_data[6:0];
                lcdnw_pkg::CFG_SECOND_LINE_CMD: r_second_line_cmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Counter update for a data character. The counter sticks at its top
    // value and then never triggers a wrap. A zero line length never matches.
    always_comb begin
        count_base   = s_tdata[8] ? 7'd0 : r_char_count;
        n_char_count = r_char_count;
        n_wrap       = 1'b0;
        if (in_cmd == lcdnw_pkg::CMD_DATA) begin
            n_char_count = count_base;
            if (count_base < lcdnw_pkg::COUNT_MAX) begin
                n_char_count = 7'(count_base + 7'd1);
                n_wrap       = (n_char_count == r_line_length);
            end
        end
    end

    lcdnw_strobe_gen u_strobe_gen (
        .i_kind     (r_b_kind),
        .i_byte     (r_b_byte),
        .i_wrap     (r_b_wrap),
        .i_wrap_cmd (r_second_line_cmd),
        .i_idx      (r_b_idx),
        .o_strobe   (strobe)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_char_count <= 7'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_b_valid;
            end
            if (in_fire) begin
                r_b_valid    <= 1'b1;
                r_char_count <= n_char_count;
            end else if (r_b_valid && out_free && strobe.last) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b_kind <= in_cmd;
            r_b_byte <= s_tdata[7:0];
            r_b_wrap <= n_wrap;
            r_b_idx  <= 4'd0;
        end else if (r_b_valid && out_free) begin
            r_b_idx <= 4'(r_b_idx + 4'd1);
        end
        if (out_free) begin
            r_out <= strobe;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out.settle_count, r_out.nibble};
    assign m_tuser  = r_out.reg_select;
    assign m_tlast  = r_out.last;

endmodule
